FILE: hdl/pbet_pkg.sv
// Shared widths, operation codes, time constants and control structs for the ban table.
package pbet_pkg;

  localparam int OP_W   = 3;
  localparam int ADDR_W = 64;
  localparam int TIME_W = 63;
  localparam int DUR_W  = 32;
  localparam int ENTRY_W = 2 * ADDR_W + TIME_W;

  localparam logic [OP_W-1:0] OP_CHECK        = 3'd0;
  localparam logic [OP_W-1:0] OP_BAN_DEFAULT  = 3'd1;
  localparam logic [OP_W-1:0] OP_BAN_UNTIL    = 3'd2;
  localparam logic [OP_W-1:0] OP_BAN_LIFETIME = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR        = 3'd4;

  localparam logic [TIME_W-1:0] TIME_MAX        = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] LIFETIME_EXPIRY = 63'h00FF_FFFF_FFFF_FFFF;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // word accepted, latch payload and restart the scan
    logic rd_en;   // read table entry at scan index, advance index
    logic finish;  // apply update and push result word
  } pbet_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_op;    // incoming op needs a table scan
    logic scan_last;  // scan index is at the last entry
    logic out_free;   // result register can take a word this cycle
  } pbet_sts_t;

endpackage

FILE: hdl/pbet_req_if.sv
// Request channel: operation, address and times, valid/ready handshake.
interface pbet_req_if;
  logic                             valid;
  logic                             ready;
  logic [pbet_pkg::OP_W-1:0]        op;
  logic [pbet_pkg::ADDR_W-1:0]      addr_high;
  logic [pbet_pkg::ADDR_W-1:0]      addr_low;
  logic [pbet_pkg::TIME_W-1:0]      now;
  logic [pbet_pkg::TIME_W-1:0]      until_time;

  modport source (output valid, op, addr_high, addr_low, now, until_time, input ready);
  modport sink   (input valid, op, addr_high, addr_low, now, until_time, output ready);
endinterface

FILE: hdl/pbet_rsp_if.sv
// Response channel: ban flag and status, valid/ready handshake.
interface pbet_rsp_if;
  logic valid;
  logic ready;
  logic is_banned;
  logic status;

  modport source (output valid, is_banned, status, input ready);
  modport sink   (input valid, is_banned, status, output ready);
endinterface

FILE: hdl/pbet_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pbet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  output logic [WIDTH-1:0]      rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: hdl/pbet_ctrl.sv
// Controller state machine: accept, scan, drain, finish.
module pbet_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pbet_pkg::pbet_sts_t sts,
  output pbet_pkg::pbet_cmd_t cmd
);
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.scan_op ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.rd_en  = (state == S_SCAN);
  assign cmd.finish = (state == S_FINISH) && sts.out_free;

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_SCAN) || (state == S_FINISH))
    else $error("accepted word did not start processing");

  a_scan_runs_to_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && !sts.scan_last |=> (state == S_SCAN))
    else $error("scan left before last entry");

  a_drain_then_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (state == S_FINISH))
    else $error("drain not followed by finish");
endmodule

FILE: hdl/pbet_dp.sv
// Datapath: payload latch, ban time, table RAM, scan compare, update and result register.
module pbet_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [pbet_pkg::DUR_W-1:0]       cfg_wr_data,
  input  logic [pbet_pkg::OP_W-1:0]        op,
  input  logic [pbet_pkg::ADDR_W-1:0]      addr_high,
  input  logic [pbet_pkg::ADDR_W-1:0]      addr_low,
  input  logic [pbet_pkg::TIME_W-1:0]      now,
  input  logic [pbet_pkg::TIME_W-1:0]      until_time,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             is_banned,
  output logic                             status,
  input  pbet_pkg::pbet_cmd_t              cmd,
  output pbet_pkg::pbet_sts_t              sts
);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam int TW = pbet_pkg::TIME_W;
  localparam int AW = pbet_pkg::ADDR_W;

  logic [pbet_pkg::DUR_W-1:0]  duration;
  logic [pbet_pkg::OP_W-1:0]   op_q;
  logic [AW-1:0]               hi_q;
  logic [AW-1:0]               lo_q;
  logic [TW-1:0]               now_q;
  logic [TW-1:0]               ban_time;
  logic [TW-1:0]               ban_time_next;
  logic [TW:0]                 rel_sum;

  logic [TABLE_ENTRIES-1:0]    valid;
  logic [IDX_W-1:0]            idx;
  logic                        cmp_en;
  logic [IDX_W-1:0]            cmp_idx;
  logic                        match_found;
  logic [IDX_W-1:0]            match_idx;
  logic [TW-1:0]               match_exp;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;

  logic [pbet_pkg::ENTRY_W-1:0] rd_data;
  logic [AW-1:0]               rd_hi;
  logic [AW-1:0]               rd_lo;
  logic [TW-1:0]               rd_exp;
  logic                        hit;

  logic                        is_ban;
  logic                        we;
  logic [IDX_W-1:0]            wr_idx;
  logic [TW-1:0]               wr_exp;
  logic                        banned_next;
  logic                        full_next;

  // relative ban: now + duration, clamp at max time
  assign rel_sum = (TW+1)'(now) + (TW+1)'(duration);

  always_comb begin
    case (op)
      pbet_pkg::OP_BAN_DEFAULT:  ban_time_next = rel_sum[TW] ? pbet_pkg::TIME_MAX
                                                             : rel_sum[TW-1:0];
      pbet_pkg::OP_BAN_UNTIL:    ban_time_next = until_time;
      pbet_pkg::OP_BAN_LIFETIME: ban_time_next = pbet_pkg::LIFETIME_EXPIRY;
      default:                   ban_time_next = '0;
    endcase
  end

  assign sts.scan_op   = op inside {pbet_pkg::OP_CHECK, pbet_pkg::OP_BAN_DEFAULT,
                                    pbet_pkg::OP_BAN_UNTIL, pbet_pkg::OP_BAN_LIFETIME};
  assign sts.scan_last = (idx == LAST_IDX);
  assign sts.out_free  = !out_valid || out_ready;

  assign {rd_hi, rd_lo, rd_exp} = rd_data;
  assign hit = valid[cmp_idx] && (rd_hi == hi_q) && (rd_lo == lo_q);

  // finish-time decisions
  assign is_ban = op_q inside {pbet_pkg::OP_BAN_DEFAULT, pbet_pkg::OP_BAN_UNTIL,
                               pbet_pkg::OP_BAN_LIFETIME};
  assign we          = cmd.finish && is_ban && (match_found || free_found);
  assign wr_idx      = match_found ? match_idx : free_idx;
  assign wr_exp      = (match_found && (match_exp > ban_time)) ? match_exp : ban_time;
  assign banned_next = (op_q == pbet_pkg::OP_CHECK) && match_found && (now_q < match_exp);
  assign full_next   = is_ban && !match_found && !free_found;

  pbet_ram #(
    .WIDTH (pbet_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_idx),
    .wr_data ({hi_q, lo_q, wr_exp}),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      duration    <= '0;
      valid       <= '0;
      idx         <= '0;
      cmp_en      <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        duration <= cfg_wr_data;
      end
      cmp_en <= cmd.rd_en;
      if (cmd.load) begin
        idx         <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (cmd.rd_en) begin
        idx <= idx + 1'b1;
      end
      if (cmp_en) begin
        if (hit) begin
          match_found <= 1'b1;
        end
        if (!valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.finish) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
        if (op_q == pbet_pkg::OP_CLEAR) begin
          valid <= '0;
        end else if (we && !match_found) begin
          valid[free_idx] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_idx <= idx;
    if (cmd.load) begin
      op_q     <= op;
      hi_q     <= addr_high;
      lo_q     <= addr_low;
      now_q    <= now;
      ban_time <= ban_time_next;
    end
    if (cmp_en && hit) begin
      match_idx <= cmp_idx;
      match_exp <= rd_exp;
    end
    if (cmp_en && !valid[cmp_idx] && !free_found) begin
      free_idx <= cmp_idx;
    end
    if (cmd.finish) begin
      is_banned <= banned_next;
      status    <= full_next ? pbet_pkg::STATUS_FULL : pbet_pkg::STATUS_DONE;
    end
  end

  a_match_is_live: assert property (@(posedge clk) disable iff (rst)
    match_found |-> valid[match_idx])
    else $error("matched slot is not valid");

  a_free_is_free: assert property (@(posedge clk) disable iff (rst)
    free_found |-> !valid[free_idx])
    else $error("chosen free slot is occupied");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && full_next |-> &valid)
    else $error("full status with a free slot");

  a_no_push_on_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result pushed over a waiting word");
endmodule

FILE: hdl/peer_ban_expiry_table.sv
// Top level of the peer ban expiry table: controller, datapath and channel wiring.
// Check and ban words: the table RAM is scanned one entry per cycle through its single
//   read port, then a drain state comes before the finish state registers the result.
// Clear and unused op codes skip the scan and go straight to the finish state.
// A new word is accepted only once the finish state has registered the current result.
// Reset (rst, synchronous): valid bits and the duration register clear at once, RAM left as is.
module peer_ban_expiry_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pbet_pkg::DUR_W-1:0]   cfg_wr_data,
  pbet_req_if.sink                     req,
  pbet_rsp_if.source                   rsp
);
  // command and status between the state machine and the datapath
  pbet_pkg::pbet_cmd_t cmd;
  pbet_pkg::pbet_sts_t sts;
  logic                ready;

  // controller: waits for a word in idle, walks the scan, then finishes once the
  // result register can take the word (a waiting result does not block accept)
  pbet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign req.ready = ready;

  // datapath: holds the table (valid bits in flops, entries in RAM), the
  // compare stage behind the RAM read register, and the result register
  pbet_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op          (req.op),
    .addr_high   (req.addr_high),
    .addr_low    (req.addr_low),
    .now         (req.now),
    .until_time  (req.until_time),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .is_banned   (rsp.is_banned),
    .status      (rsp.status),
    .cmd         (cmd),
    .sts         (sts)
  );

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second word accepted while busy");

  a_result_needs_word: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !req.ready)
    else $error("result produced from idle");

  a_rd_only_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !req.ready)
    else $error("table read while idle");
endmodule

FILE: bench/peer_ban_expiry_table_test.sv
// Self-checking bench for the peer ban expiry table: directed ban cases, then randomized traffic.
module peer_ban_expiry_table_test;

  localparam int TABLE_ENTRIES = 16;
  // Check/ban words scan all TABLE_ENTRIES slots; a little margin on top.
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 6;
  // Cycles with no accepted word on either channel before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  localparam int WORDS_PER_PHASE = 82;

  // Op codes the block treats as no-ops.
  localparam logic [pbet_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [pbet_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic banned;
    logic status;
  } ban_verdict_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [pbet_pkg::DUR_W-1:0] cfg_wr_data;

  pbet_req_if req_ch ();
  pbet_rsp_if rsp_ch ();

  peer_ban_expiry_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the ban table and the duration register
  // ---------------------------------------------------------------------------
  logic                        shadow_valid [TABLE_ENTRIES];
  logic [pbet_pkg::ADDR_W-1:0] shadow_hi    [TABLE_ENTRIES];
  logic [pbet_pkg::ADDR_W-1:0] shadow_lo    [TABLE_ENTRIES];
  logic [pbet_pkg::TIME_W-1:0] shadow_expiry[TABLE_ENTRIES];
  logic [pbet_pkg::DUR_W-1:0]  shadow_duration;

  // Verdicts owed by the block, oldest first.
  ban_verdict_t pending_verdicts[$];

  int fail_count;
  int words_sent;
  int verdicts_checked;
  int drops_seen;
  int hits_seen;
  int idle_cycles;
  bit steady;  // set for the tail of the run: no idling on either side

  // Address pool for the random traffic, so bans and checks collide.
  localparam int POOL_SIZE = 24;
  logic [pbet_pkg::ADDR_W-1:0] pool_hi[POOL_SIZE];
  logic [pbet_pkg::ADDR_W-1:0] pool_lo[POOL_SIZE];

  function automatic void clear_shadow();
    for (int i = 0; i < TABLE_ENTRIES; i++) shadow_valid[i] = 1'b0;
  endfunction

  function automatic int find_entry(logic [pbet_pkg::ADDR_W-1:0] hi,
                                    logic [pbet_pkg::ADDR_W-1:0] lo);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (shadow_valid[i] && shadow_hi[i] == hi && shadow_lo[i] == lo) return i;
    return -1;
  endfunction

  // Raise-only ban; a miss takes the lowest free slot, or is dropped when full.
  function automatic logic apply_ban(logic [pbet_pkg::ADDR_W-1:0] hi,
                                     logic [pbet_pkg::ADDR_W-1:0] lo,
                                     logic [pbet_pkg::TIME_W-1:0] expiry);
    int slot;
    slot = find_entry(hi, lo);
    if (slot >= 0) begin
      if (shadow_expiry[slot] < expiry) shadow_expiry[slot] = expiry;
      return pbet_pkg::STATUS_DONE;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!shadow_valid[i]) begin
        shadow_valid[i]  = 1'b1;
        shadow_hi[i]     = hi;
        shadow_lo[i]     = lo;
        shadow_expiry[i] = expiry;
        return pbet_pkg::STATUS_DONE;
      end
    end
    return pbet_pkg::STATUS_FULL;
  endfunction

  function automatic ban_verdict_t predict_verdict(logic [pbet_pkg::OP_W-1:0] op,
                                                   logic [pbet_pkg::ADDR_W-1:0] hi,
                                                   logic [pbet_pkg::ADDR_W-1:0] lo,
                                                   logic [pbet_pkg::TIME_W-1:0] cur_time,
                                                   logic [pbet_pkg::TIME_W-1:0] until_t);
    ban_verdict_t v;
    logic [pbet_pkg::TIME_W:0] sum;
    int slot;
    v.banned = 1'b0;
    v.status = pbet_pkg::STATUS_DONE;
    case (op)
      pbet_pkg::OP_CHECK: begin
        slot = find_entry(hi, lo);
        if (slot >= 0 && cur_time < shadow_expiry[slot]) v.banned = 1'b1;
      end
      pbet_pkg::OP_BAN_DEFAULT: begin
        // one extra bit catches the carry; saturate at the top of the time range
        sum = {1'b0, cur_time} +
              {{(pbet_pkg::TIME_W + 1 - pbet_pkg::DUR_W){1'b0}}, shadow_duration};
        if (sum > {1'b0, pbet_pkg::TIME_MAX}) sum = {1'b0, pbet_pkg::TIME_MAX};
        v.status = apply_ban(hi, lo, sum[pbet_pkg::TIME_W-1:0]);
      end
      pbet_pkg::OP_BAN_UNTIL:    v.status = apply_ban(hi, lo, until_t);
      pbet_pkg::OP_BAN_LIFETIME: v.status = apply_ban(hi, lo, pbet_pkg::LIFETIME_EXPIRY);
      pbet_pkg::OP_CLEAR:        clear_shadow();
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL peer_ban_expiry_table");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: random backpressure, and the checker
  // ---------------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Signals read right after the edge still hold their pre-edge values.
  always @(posedge clk) begin
    ban_verdict_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_failure($sformatf("result word with nothing outstanding (banned %b status %b)",
                                 rsp_ch.is_banned, rsp_ch.status));
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (rsp_ch.is_banned !== want.banned)
          report_failure($sformatf("is_banned expected %b got %b", want.banned,
                                   rsp_ch.is_banned));
        if (rsp_ch.status !== want.status)
          report_failure($sformatf("status expected %b got %b", want.status,
                                   rsp_ch.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Called right after a rising edge. valid is left high after acceptance so that
  // back-to-back words keep it high; a gap or a drain lowers it.
  task automatic send_word(logic [pbet_pkg::OP_W-1:0] op, logic [pbet_pkg::ADDR_W-1:0] hi,
                           logic [pbet_pkg::ADDR_W-1:0] lo,
                           logic [pbet_pkg::TIME_W-1:0] cur_time,
                           logic [pbet_pkg::TIME_W-1:0] until_t);
    ban_verdict_t v;
    if (!steady && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_ch.op         <= op;
    req_ch.addr_high  <= hi;
    req_ch.addr_low   <= lo;
    req_ch.now        <= cur_time;
    req_ch.until_time <= until_t;
    req_ch.valid      <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge: update the shadow table and queue the verdict
    v = predict_verdict(op, hi, lo, cur_time, until_t);
    pending_verdicts.push_back(v);
    words_sent++;
    if (v.status == pbet_pkg::STATUS_FULL) drops_seen++;
    if (v.banned) hits_seen++;
  endtask

  // Sender pauses until every verdict is back, then lets the scan wind down.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_duration(logic [pbet_pkg::DUR_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_duration = value;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Times mostly cluster around a per-phase base so expiries and checks overlap;
  // the rest hit zero, the top of the range, or anything at all.
  function automatic logic [pbet_pkg::TIME_W-1:0] pick_time(
      logic [pbet_pkg::TIME_W-1:0] base);
    int roll;
    logic [63:0] r;
    roll = $urandom_range(0, 99);
    r = rand64();
    if (roll < 70) return base + pbet_pkg::TIME_W'($urandom_range(0, 4000));
    if (roll < 78) return '0;
    if (roll < 88) return pbet_pkg::TIME_MAX - pbet_pkg::TIME_W'($urandom_range(0, 8));
    return r[pbet_pkg::TIME_W-1:0];
  endfunction

  function automatic logic [pbet_pkg::OP_W-1:0] pick_unused_op();
    return pbet_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Freshly reset table: nothing is banned.
  task automatic test_empty_after_reset();
    send_word(pbet_pkg::OP_CHECK, '0, '0, '0, '0);
    send_word(pbet_pkg::OP_CHECK, '1, '1, '0, pbet_pkg::TIME_MAX);
  endtask

  // Ban time corner cases, with the widest default duration.
  task automatic test_ban_times();
    logic [pbet_pkg::ADDR_W-1:0] c_hi, c_lo, d_lo;
    c_hi = rand64();
    c_lo = rand64();
    d_lo = rand64();
    write_duration({pbet_pkg::DUR_W{1'b1}});
    // a miss with ban time zero still takes a slot, but bans nothing
    send_word(pbet_pkg::OP_BAN_UNTIL, '0, '0, '0, '0);
    send_word(pbet_pkg::OP_CHECK, '0, '0, '0, '0);
    // expiry at the top of the range; check is strict
    send_word(pbet_pkg::OP_BAN_UNTIL, '1, '1, '0, pbet_pkg::TIME_MAX);
    send_word(pbet_pkg::OP_CHECK, '1, '1, pbet_pkg::TIME_MAX - 1, '0);
    send_word(pbet_pkg::OP_CHECK, '1, '1, pbet_pkg::TIME_MAX, '0);
    // lifetime ban, then an earlier ban that must not lower it
    send_word(pbet_pkg::OP_BAN_LIFETIME, c_hi, c_lo, '0, '0);
    send_word(pbet_pkg::OP_BAN_UNTIL, c_hi, c_lo, '0, 63'd5);
    send_word(pbet_pkg::OP_CHECK, c_hi, c_lo, pbet_pkg::LIFETIME_EXPIRY - 1, '0);
    // same upper half, other lower half: a different address
    send_word(pbet_pkg::OP_CHECK, c_hi, ~c_lo, '0, '0);
    // relative ban that runs past the top of the range saturates
    send_word(pbet_pkg::OP_BAN_DEFAULT, '0, d_lo, pbet_pkg::TIME_MAX - 3, '0);
    send_word(pbet_pkg::OP_CHECK, '0, d_lo, pbet_pkg::TIME_MAX - 1, '0);
  endtask

  // Unused codes change nothing; clear drops every entry.
  task automatic test_unused_and_clear();
    for (int k = int'(OP_UNUSED_LO); k <= int'(OP_UNUSED_HI); k++)
      send_word(pbet_pkg::OP_W'(k), '1, '1, '0, '0);
    send_word(pbet_pkg::OP_CHECK, '1, '1, '0, '0);
    send_word(pbet_pkg::OP_CLEAR, '0, '0, '0, '0);
    send_word(pbet_pkg::OP_CHECK, '1, '1, '0, '0);
  endtask

  // Fill every slot, then a new address is dropped while a known one still updates.
  task automatic test_table_full();
    logic [pbet_pkg::ADDR_W-1:0] first_hi, first_lo;
    first_hi = rand64();
    first_lo = rand64();
    write_duration(32'd1000);
    send_word(pbet_pkg::OP_BAN_DEFAULT, first_hi, first_lo, 63'd100, '0);
    for (int i = 1; i < TABLE_ENTRIES; i++)
      send_word(pbet_pkg::OP_BAN_UNTIL, rand64(), rand64(), '0, 63'd500);
    send_word(pbet_pkg::OP_BAN_LIFETIME, rand64(), rand64(), '0, '0);
    send_word(pbet_pkg::OP_BAN_UNTIL, first_hi, first_lo, '0, 63'd5000);
    send_word(pbet_pkg::OP_CHECK, first_hi, first_lo, 63'd4999, '0);
    send_word(pbet_pkg::OP_CLEAR, '0, '0, '0, '0);
  endtask

  // Pool addresses: some share an upper or lower half, plus the two extremes.
  task automatic build_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_hi[i] = rand64();
      pool_lo[i] = rand64();
    end
    pool_hi[1] = pool_hi[0];
    pool_lo[3] = pool_lo[2];
    pool_hi[5] = pool_hi[4];
    pool_hi[6] = '0;
    pool_lo[6] = '0;
    pool_hi[7] = '1;
    pool_lo[7] = '1;
  endtask

  task automatic random_word(logic [pbet_pkg::TIME_W-1:0] base);
    int roll, slot;
    logic [pbet_pkg::OP_W-1:0] op;
    logic [pbet_pkg::ADDR_W-1:0] hi, lo;
    roll = $urandom_range(0, 99);
    if (roll < 40)      op = pbet_pkg::OP_CHECK;
    else if (roll < 60) op = pbet_pkg::OP_BAN_DEFAULT;
    else if (roll < 80) op = pbet_pkg::OP_BAN_UNTIL;
    else if (roll < 90) op = pbet_pkg::OP_BAN_LIFETIME;
    else if (roll < 94) op = pbet_pkg::OP_CLEAR;
    else                op = pick_unused_op();
    if ($urandom_range(0, 99) < 88) begin
      slot = $urandom_range(0, POOL_SIZE - 1);
      hi = pool_hi[slot];
      lo = pool_lo[slot];
    end else begin
      hi = rand64();
      lo = rand64();
    end
    send_word(op, hi, lo, pick_time(base), pick_time(base));
  endtask

  // Several duration settings, the extremes among them; the last phase runs
  // with no idling on either side.
  task automatic test_random_traffic();
    logic [pbet_pkg::DUR_W-1:0] settings[5];
    logic [63:0] r;
    build_pool();
    settings[0] = pbet_pkg::DUR_W'($urandom_range(1, 3000));
    settings[1] = '0;
    settings[2] = {pbet_pkg::DUR_W{1'b1}};
    settings[3] = $urandom;
    settings[4] = pbet_pkg::DUR_W'($urandom_range(1, 3000));
    for (int phase = 0; phase < 5; phase++) begin
      write_duration(settings[phase]);
      if (phase == 4) steady = 1'b1;
      r = rand64();
      for (int n = 0; n < WORDS_PER_PHASE; n++) random_word(r[pbet_pkg::TIME_W-1:0]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    req_ch.valid      = 1'b0;
    req_ch.op         = pbet_pkg::OP_CHECK;
    req_ch.addr_high  = '0;
    req_ch.addr_low   = '0;
    req_ch.now        = '0;
    req_ch.until_time = '0;
    steady            = 1'b0;
    fail_count        = 0;
    words_sent        = 0;
    verdicts_checked  = 0;
    drops_seen        = 0;
    hits_seen         = 0;
    idle_cycles       = 0;
    clear_shadow();
    shadow_duration   = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_after_reset();
    test_ban_times();
    test_unused_and_clear();
    test_table_full();
    test_random_traffic();
    wait_idle();

    if (pending_verdicts.size() != 0)
      report_failure($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

    $display("sent %0d words over five duration settings, checked %0d results",
             words_sent, verdicts_checked);
    $display("%0d bans dropped on a full table, %0d checks found an active ban, %0d failures",
             drops_seen, hits_seen, fail_count);
    if (fail_count == 0)
      $display("PASS peer_ban_expiry_table");
    else
      $display("FAIL peer_ban_expiry_table");
    $finish;
  end

endmodule
